// ===== sv/firw_pkg.sv =====
`timescale 1ns / 1ps

package firw_pkg;

  localparam int TAPS       = 8;
  localparam int NUM_COEFS  = 8;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int OUT_W      = 35;
  localparam int SLOT_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FILL_W     = $clog2(TAPS + 1);
  localparam int COEF_IDX_W = $clog2(NUM_COEFS);
  localparam int CFG_IDX_W  = COEF_IDX_W + 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [OUT_W-1:0]    acc_t;

endpackage

// ===== sv/fir_filter_with_warmup.sv =====
`timescale 1ns / 1ps

// FIR filter with warm-up: every accepted sample gives exactly one result word.
// The first TAPS-1 samples after reset return status 1 and filtered 0; from then
// on filtered is the exact signed 35-bit sum of coef_(TAPS-1-k) times the
// sample k steps old. The delay line sits in a one-port-read synchronous RAM and
// one shared 16x16 multiplier walks the taps with one RAM read per tap: each tap
// passes the registered RAM read, the product register and the accumulator, and
// the sum then goes to the output register. A warm-up item skips the taps and
// goes straight to the done state. The next sample can be taken in the same
// cycle as the word appears. A finished word waits in the output register while
// the next sample is taken; while that word is stalled, the next finished word
// holds the input off. Coefficients must be written through the cfg port while
// the block is idle; the block itself does not enforce this.
module fir_filter_with_warmup (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [firw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [firw_pkg::COEF_W-1:0]          cfg_data,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [firw_pkg::SAMPLE_W-1:0] sample,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [firw_pkg::OUT_W-1:0]    filtered,
  output logic                                 status
);

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_DONE} state_t;

  state_t                          state;
  firw_pkg::coef_t                 coef [firw_pkg::NUM_COEFS];
  firw_pkg::sample_t               line_mem [firw_pkg::TAPS];
  firw_pkg::sample_t               mem_rd;
  logic [firw_pkg::SLOT_W-1:0]     rd_addr;

  logic [firw_pkg::SLOT_W-1:0]     write_slot;
  logic [firw_pkg::SLOT_W-1:0]     write_slot_next;
  logic [firw_pkg::SLOT_W-1:0]     base_slot;
  logic [firw_pkg::FILL_W-1:0]     fill_count;
  logic [firw_pkg::FILL_W-1:0]     fill_count_next;
  firw_pkg::sample_t               newest;

  logic                            issuing;
  logic [firw_pkg::SLOT_W-1:0]     issue_k;
  logic                            rd_v;
  logic                            rd_last;
  logic [firw_pkg::SLOT_W-1:0]     rd_k;
  logic                            prod_v;
  logic                            prod_last;
  firw_pkg::prod_t                 prod;
  firw_pkg::acc_t                  acc;
  firw_pkg::acc_t                  acc_next;

  firw_pkg::acc_t                  res_filtered;
  logic                            res_status;

  logic                            accept;
  logic [firw_pkg::SLOT_W:0]       pos_wide;
  logic [firw_pkg::COEF_IDX_W-1:0] coef_sel;
  firw_pkg::sample_t               op_sample;
  firw_pkg::prod_t                 prod_next;

  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;

  assign fill_count_next = (fill_count < firw_pkg::FILL_W'(firw_pkg::TAPS))
                         ? fill_count + 1'b1 : fill_count;
  assign write_slot_next = (write_slot == firw_pkg::SLOT_W'(firw_pkg::TAPS - 1))
                         ? '0 : write_slot + 1'b1;

  // slot of the sample issue_k steps old, wrapping below zero
  always_comb begin
    if (base_slot >= issue_k) begin
      pos_wide = {1'b0, base_slot} - {1'b0, issue_k};
    end else begin
      pos_wide = {1'b0, base_slot} + (firw_pkg::SLOT_W+1)'(firw_pkg::TAPS)
               - {1'b0, issue_k};
    end
  end
  assign rd_addr = pos_wide[firw_pkg::SLOT_W-1:0];

  // newest sample is forwarded, the rest come from the line RAM
  assign op_sample = (rd_k == '0) ? newest : mem_rd;
  assign coef_sel  = firw_pkg::COEF_IDX_W'(firw_pkg::TAPS - 1)
                   - firw_pkg::COEF_IDX_W'(rd_k);
  assign prod_next = op_sample * coef[coef_sel];
  assign acc_next  = acc + firw_pkg::OUT_W'(prod);

  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[write_slot] <= sample;
    end
    mem_rd <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < firw_pkg::NUM_COEFS; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_write &&
                 (cfg_index < firw_pkg::CFG_IDX_W'(firw_pkg::NUM_COEFS))) begin
      coef[cfg_index[firw_pkg::COEF_IDX_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      write_slot   <= '0;
      fill_count   <= '0;
      issuing      <= 1'b0;
      issue_k      <= '0;
      rd_v         <= 1'b0;
      prod_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_v      <= 1'b0;
      prod_v    <= rd_v;
      prod_last <= rd_last;
      if (rd_v) begin
        prod <= prod_next;
      end

      if (issuing) begin
        rd_v    <= 1'b1;
        rd_k    <= issue_k;
        rd_last <= (issue_k == firw_pkg::SLOT_W'(firw_pkg::TAPS - 1));
        if (issue_k == firw_pkg::SLOT_W'(firw_pkg::TAPS - 1)) begin
          issuing <= 1'b0;
        end else begin
          issue_k <= issue_k + 1'b1;
        end
      end

      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            write_slot <= write_slot_next;
            fill_count <= fill_count_next;
            base_slot  <= write_slot;
            newest     <= sample;
            acc        <= '0;
            if (fill_count_next < firw_pkg::FILL_W'(firw_pkg::TAPS)) begin
              res_filtered <= '0;
              res_status   <= 1'b1;
              state        <= S_DONE;
            end else begin
              issuing <= 1'b1;
              issue_k <= '0;
              state   <= S_MAC;
            end
          end
        end
        S_MAC: begin
          if (prod_v) begin
            acc <= acc_next;
            if (prod_last) begin
              res_filtered <= acc_next;
              res_status   <= 1'b0;
              state        <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!result_valid || !result_stall) begin
            filtered     <= res_filtered;
            status       <= res_status;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!issuing && !rd_v && !prod_v))
    else $error("sample taken while the tap pipeline is busy");

  a_wait_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status) |-> (filtered == '0))
    else $error("waiting word carries a nonzero value");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= firw_pkg::FILL_W'(firw_pkg::TAPS))
    else $error("fill count passed the tap count");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC && prod_v && prod_last) |=> (state == S_DONE))
    else $error("last tap did not finish the item");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(filtered)))
    else $error("stalled result word changed");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int COEF_REG_0    = 0;
  localparam int CFG_REGS      = 1 << firw_pkg::CFG_IDX_W;
  localparam int PHASE_COUNT   = 7;
  localparam int PHASE_WORDS   = 250;
  localparam int HOLD_CYCLES   = 200;

  localparam firw_pkg::sample_t SAMPLE_MIN =
    firw_pkg::sample_t'(1 << (firw_pkg::SAMPLE_W - 1));
  localparam firw_pkg::sample_t SAMPLE_MAX = ~SAMPLE_MIN;
  localparam firw_pkg::coef_t   COEF_MIN   =
    firw_pkg::coef_t'(1 << (firw_pkg::COEF_W - 1));
  localparam firw_pkg::coef_t   COEF_MAX   = ~COEF_MIN;

  typedef struct packed {
    firw_pkg::acc_t filtered;
    logic           status;
  } fir_word_t;

  typedef firw_pkg::coef_t coef_set_t [firw_pkg::NUM_COEFS];

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [firw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [firw_pkg::COEF_W-1:0]    cfg_data;
  logic                           sample_valid;
  logic                           sample_stall;
  firw_pkg::sample_t              sample;
  logic                           result_valid;
  logic                           result_stall;
  firw_pkg::acc_t                 filtered;
  logic                           status;

  fir_filter_with_warmup dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered     (filtered),
    .status       (status)
  );

  // Filter state as the testbench sees it
  firw_pkg::sample_t tap_line [firw_pkg::TAPS];
  firw_pkg::coef_t   coef_bank [firw_pkg::NUM_COEFS];
  int unsigned       next_slot;
  int unsigned       samples_seen;
  fir_word_t         awaited_words [$];
  fir_word_t         oldest_word;

  int                failures = 0;
  int                send_max_gap;
  int                recv_max_stall;
  int                hold_request;
  int unsigned       cycle_count = 0;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** fir_filter_with_warmup: FAILED **");
      $finish;
    end
  end

  function automatic fir_word_t filter_word(firw_pkg::sample_t s);
    int unsigned     slot;
    firw_pkg::acc_t  sum;
    firw_pkg::prod_t p;
    fir_word_t       w;
    slot = next_slot;
    tap_line[slot] = s;
    if (samples_seen < firw_pkg::TAPS) samples_seen++;
    if (samples_seen < firw_pkg::TAPS) begin
      w.filtered = '0;
      w.status   = 1'b1;
    end else begin
      sum = '0;
      for (int k = 0; k < firw_pkg::TAPS; k++) begin
        p   = tap_line[(slot + firw_pkg::TAPS - k) % firw_pkg::TAPS]
            * coef_bank[firw_pkg::TAPS - 1 - k];
        sum = sum + firw_pkg::acc_t'(p);
      end
      w.filtered = sum;
      w.status   = 1'b0;
    end
    next_slot = (slot + 1 == firw_pkg::TAPS) ? 0 : slot + 1;
    return w;
  endfunction

  function automatic firw_pkg::sample_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return '0;
      3:       return '1;
      default: return firw_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic firw_pkg::coef_t rand_coef();
    case ($urandom_range(0, 5))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      default: return firw_pkg::coef_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(firw_pkg::sample_t s);
    int gap;
    gap = $urandom_range(0, send_max_gap);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    awaited_words.push_back(filter_word(s));
  endtask

  // Drop valid and wait for every outstanding word, then let the pipe settle
  task automatic drain();
    sample_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [firw_pkg::COEF_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= firw_pkg::CFG_IDX_W'(idx);
    cfg_data  <= data;
    @(posedge clk);
    if (idx < firw_pkg::NUM_COEFS) coef_bank[idx] = firw_pkg::coef_t'(data);
  endtask

  // Load all coefficients, then hit every index past the list with junk
  task automatic write_coefs(input coef_set_t vals);
    for (int j = 0; j < firw_pkg::NUM_COEFS; j++) write_reg(COEF_REG_0 + j, vals[j]);
    for (int j = firw_pkg::NUM_COEFS; j < CFG_REGS; j++) begin
      write_reg(j, firw_pkg::COEF_W'($urandom));
    end
    cfg_write <= 1'b0;
  endtask

  task automatic test_warmup();
    send_max_gap   = 3;
    recv_max_stall = 3;
    for (int i = 0; i < firw_pkg::TAPS; i++) send_sample(SAMPLE_MIN);
    drain();
  endtask

  task automatic test_extreme_sums();
    coef_set_t vals;
    foreach (vals[j]) vals[j] = COEF_MIN;
    write_coefs(vals);
    send_sample(SAMPLE_MIN);
    drain();
    foreach (vals[j]) vals[j] = COEF_MAX;
    write_coefs(vals);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    drain();
  endtask

  task automatic test_coef_order();
    coef_set_t vals;
    foreach (vals[j]) vals[j] = firw_pkg::coef_t'(((j + 1) << 8) * ((j % 2) ? -1 : 1));
    write_coefs(vals);
    send_sample(firw_pkg::sample_t'(1));
    for (int i = 1; i < firw_pkg::TAPS; i++) send_sample('0);
    drain();
  endtask

  task automatic test_backpressure();
    coef_set_t vals;
    foreach (vals[j]) vals[j] = rand_coef();
    write_coefs(vals);
    send_max_gap = 0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) send_sample(rand_sample());
    drain();
  endtask

  task automatic test_random();
    coef_set_t vals;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0:       foreach (vals[j]) vals[j] = COEF_MAX;
        1:       foreach (vals[j]) vals[j] = COEF_MIN;
        2:       foreach (vals[j]) vals[j] = (j % 2) ? COEF_MAX : COEF_MIN;
        default: foreach (vals[j]) vals[j] = rand_coef();
      endcase
      write_coefs(vals);
      case (ph)
        3: begin send_max_gap = 0; recv_max_stall = 0; end
        4: begin send_max_gap = 3; recv_max_stall = 0; end
        5: begin send_max_gap = 0; recv_max_stall = 3; end
        default: begin send_max_gap = 3; recv_max_stall = 3; end
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) send_sample(rand_sample());
      drain();
    end
  endtask

  // Receiver: stall a random or requested time before taking each word
  initial begin
    int n;
    result_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = $urandom_range(0, recv_max_stall);
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (awaited_words.size() == 0) begin
        $error("unexpected word: filtered=%0d status=%0b", filtered, status);
        failures++;
      end else begin
        oldest_word = awaited_words.pop_front();
        if (filtered !== oldest_word.filtered) begin
          $error("filtered: expected %0d, got %0d", oldest_word.filtered, filtered);
          failures++;
        end
        if (status !== oldest_word.status) begin
          $error("status: expected %0b, got %0b", oldest_word.status, status);
          failures++;
        end
      end
    end
  end

  initial begin
    hold_request   = 0;
    send_max_gap   = 3;
    recv_max_stall = 3;
    next_slot      = 0;
    samples_seen   = 0;
    foreach (tap_line[i]) tap_line[i] = '0;
    foreach (coef_bank[i]) coef_bank[i] = '0;
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    sample_valid <= 1'b0;
    sample       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_warmup();
    test_extreme_sums();
    test_coef_order();
    test_backpressure();
    test_random();

    if (failures == 0 && awaited_words.size() == 0) begin
      $display("** fir_filter_with_warmup: PASSED **");
    end else begin
      $display("** fir_filter_with_warmup: FAILED **");
    end
    $finish;
  end

endmodule
